// ===== hw/rtl/moetg_pkg.sv =====
// Shared constants, opcodes and the result beat layout of the MoE token grouper.
package moetg_pkg;

	// Default sizing
	localparam int DEF_NUM_EXPERTS = 64;
	localparam int DEF_LIST_CAP    = 4096;

	// Token indices are 12 bits wide, so a batch holds at most this many tokens
	localparam int TOKEN_SPACE = 4096;
	localparam int MAX_ROW     = 4096;

	// Field widths
	localparam int OP_W   = 2;
	localparam int EID_W  = 6;
	localparam int SLOT_W = 12;
	localparam int TOPK_W = 7;
	localparam int TOK_W  = 12;
	localparam int CNT_W  = 13;
	localparam int HOT_W  = 32;

	// Opcodes
	localparam logic [OP_W-1:0] OP_ROUTE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_TOPK  = 2'd2;

	// Result beat, token_index in the lowest bits
	typedef struct packed {
		logic             overflow;
		logic [HOT_W-1:0] hot_level;
		logic [EID_W-1:0] hot_expert;
		logic [CNT_W-1:0] expert_count;
		logic [TOK_W-1:0] token_index;
	} res_t;

endpackage

// ===== hw/rtl/moetg_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module moetg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/moe_token_grouper_topk.sv =====
// Top level of the MoE token grouper: per-expert token lists, counts, hotness and top-k report.
//
// Usage: each input beat carries an opcode in s_tuser. A route beat appends the running
// token index of the batch to the addressed expert's list and returns the slot's token
// index and the new count; new_batch on a route beat first empties every list and restarts
// the token counter. A read beat returns the token stored at (expert, slot) with the count.
// A top-k beat returns one beat per reported expert, hottest first, ties to the lower id,
// with m_tlast on the final one; a top_k of zero reports one expert. Opcode 3 is taken
// and produces nothing. Routes that find the batch or the list full are dropped and flagged
// by overflow. Hotness counts every stored route since reset and saturates at all ones.
// Timing: the block takes one beat at a time. A route or read beat is accepted, then its
// registered RAM read completes and the result is loaded. For top-k, each reported expert
// is found by one sweep of the single 32-bit compare unit over the hotness RAM, one entry a
// cycle; state SDONE then compares the last entry, CNTRD fetches the expert's count and
// TEMIT loads the result. A full output register parts the sides; the block stalls only
// when a new result finds it still occupied. Counts and hotness live in RAMs backed by
// per-entry valid flops, so no clearing pass runs after reset or on new_batch. The token
// list RAM holds NUM_EXPERTS rows of 2**ceil(log2(min(LIST_CAP, 4096))) entries.
module moe_token_grouper_topk
	import moetg_pkg::*;
#(
	parameter int NUM_EXPERTS = DEF_NUM_EXPERTS,
	parameter int LIST_CAP    = DEF_LIST_CAP
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // expert_id[5:0], slot[17:6], top_k[24:18], zero[31:25]
	input  logic [2:0]  s_tuser,  // opcode[1:0], new_batch[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // token_index[11:0], expert_count[24:12], hot_expert[30:25],
	                              // hot_level[62:31], overflow[63]
	output logic        m_tlast
);

	localparam int EW       = $clog2(NUM_EXPERTS);
	localparam int EFF_CAP  = (LIST_CAP < MAX_ROW) ? LIST_CAP : MAX_ROW;
	localparam int CW       = $clog2(EFF_CAP);
	localparam int TL_DEPTH = NUM_EXPERTS * (2 ** CW);
	localparam int KW       = $clog2(NUM_EXPERTS + 1);

	localparam logic [EID_W:0]  NE_X  = (EID_W + 1)'(NUM_EXPERTS);
	localparam logic [TOPK_W-1:0] NE_K = TOPK_W'(NUM_EXPERTS);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(EFF_CAP);
	localparam logic [CNT_W-1:0] TSP_C = CNT_W'(TOKEN_SPACE);

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUTE = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_SDONE = 3'd4;
	localparam logic [2:0] ST_CNTRD = 3'd5;
	localparam logic [2:0] ST_TEMIT = 3'd6;

	// Input fields
	logic [OP_W-1:0]   in_op;
	logic              in_nb;
	logic [EID_W-1:0]  in_e;
	logic [SLOT_W-1:0] in_slot;
	logic [TOPK_W-1:0] in_k;
	logic [TOPK_W-1:0] k_clamp;
	logic              acc;

	// Control state
	logic [2:0]             st_q;
	logic [NUM_EXPERTS-1:0] cnt_vld_q;
	logic [NUM_EXPERTS-1:0] hot_vld_q;
	logic [NUM_EXPERTS-1:0] taken_q;
	logic [CNT_W-1:0]       tc_q;
	logic [KW-1:0]          k_q;
	logic [KW-1:0]          i_q;
	logic [EW-1:0]          x_q;
	logic                   have_q;
	logic                   vld_s1;
	logic                   out_vld_q;

	// Payload registers
	logic [EID_W-1:0]  e_q;
	logic [SLOT_W-1:0] slot_q;
	logic [EW-1:0]     best_q;
	logic [HOT_W-1:0]  best_h_q;
	logic [EW-1:0]     idx_s1;
	res_t              out_q;
	logic              out_last_q;

	// RAM ports
	logic              cnt_we;
	logic [CNT_W-1:0]  cnt_wd;
	logic [EW-1:0]     cnt_ra;
	logic [CNT_W-1:0]  cnt_rd;
	logic              hot_we;
	logic [HOT_W-1:0]  hot_wd;
	logic [EW-1:0]     hot_ra;
	logic [HOT_W-1:0]  hot_rd;
	logic              tl_we;
	logic [EW+CW-1:0]  tl_wa;
	logic [EW+CW-1:0]  tl_ra;
	logic [TOK_W-1:0]  tl_rd;

	// Datapath
	logic [EW-1:0]    e_idx;
	logic             e_ok;
	logic [CNT_W-1:0] cnt_cur;
	logic [HOT_W-1:0] hot_cur;
	logic             tc_full;
	logic             lst_full;
	logic             do_write;
	logic             tc_adv;
	logic [HOT_W-1:0] hot_scan;
	logic             take;
	logic             out_free;
	logic             emit;
	logic             emit_last;
	logic             topk_last;
	res_t             res;

	assign in_op   = s_tuser[1:0];
	assign in_nb   = s_tuser[2];
	assign in_e    = s_tdata[5:0];
	assign in_slot = s_tdata[17:6];
	assign in_k    = s_tdata[24:18];

	assign s_tready = (st_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// Zero counts as one, clamp to the number of experts
	always_comb begin
		if (in_k == '0) begin
			k_clamp = TOPK_W'(1);
		end else if (in_k > NE_K) begin
			k_clamp = NE_K;
		end else begin
			k_clamp = in_k;
		end
	end

	assign e_idx    = e_q[EW-1:0];
	assign e_ok     = {1'b0, e_q} < NE_X;
	assign cnt_cur  = cnt_vld_q[e_idx] ? cnt_rd : '0;
	assign hot_cur  = hot_vld_q[e_idx] ? hot_rd : '0;
	assign tc_full  = tc_q >= TSP_C;
	assign lst_full = cnt_cur >= CAP_C;
	assign tc_adv   = e_ok && !tc_full;
	assign do_write = tc_adv && !lst_full;

	// Shared compare unit: one hotness entry per cycle against the running best
	assign hot_scan = hot_vld_q[idx_s1] ? hot_rd : '0;
	assign take     = vld_s1 && !taken_q[idx_s1] && (!have_q || (hot_scan > best_h_q));

	assign topk_last = (i_q == KW'(k_q - KW'(1)));

	// Read address selection: input fields at accept, held fields while busy
	always_comb begin
		if (st_q == ST_IDLE) begin
			cnt_ra = in_e[EW-1:0];
			hot_ra = in_e[EW-1:0];
			tl_ra  = {in_e[EW-1:0], in_slot[CW-1:0]};
		end else begin
			cnt_ra = ((st_q == ST_CNTRD) || (st_q == ST_TEMIT)) ? best_q : e_idx;
			hot_ra = (st_q == ST_SCAN) ? x_q : e_idx;
			tl_ra  = {e_idx, slot_q[CW-1:0]};
		end
	end

	// Route writes and the result beat of each state
	always_comb begin
		cnt_we    = 1'b0;
		hot_we    = 1'b0;
		tl_we     = 1'b0;
		cnt_wd    = cnt_cur + CNT_W'(1);
		hot_wd    = (hot_cur == '1) ? hot_cur : hot_cur + HOT_W'(1);
		tl_wa     = {e_idx, cnt_cur[CW-1:0]};
		emit      = 1'b0;
		emit_last = 1'b1;
		res       = '0;
		unique case (st_q) inside
			ST_ROUTE: begin
				emit             = out_free;
				cnt_we           = out_free && do_write;
				hot_we           = out_free && do_write;
				tl_we            = out_free && do_write;
				res.token_index  = tc_adv ? tc_q[TOK_W-1:0] : '0;
				res.expert_count = !e_ok ? '0 : (do_write ? cnt_wd : cnt_cur);
				res.overflow     = !do_write;
			end
			ST_READ: begin
				emit             = out_free;
				res.expert_count = e_ok ? cnt_cur : '0;
				res.token_index  = (e_ok && (CNT_W'(slot_q) < cnt_cur)) ? tl_rd : '0;
			end
			ST_TEMIT: begin
				emit             = out_free;
				emit_last        = topk_last;
				res.expert_count = cnt_vld_q[best_q] ? cnt_rd : '0;
				res.hot_expert   = EID_W'(best_q);
				res.hot_level    = best_h_q;
			end
			ST_IDLE, ST_SCAN, ST_SDONE, ST_CNTRD: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_vld_q <= '0;
			hot_vld_q <= '0;
			taken_q   <= '0;
			tc_q      <= '0;
			k_q       <= '0;
			i_q       <= '0;
			x_q       <= '0;
			have_q    <= 1'b0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= (st_q == ST_SCAN);
			if (take) begin
				have_q <= 1'b1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (cnt_we) begin
				cnt_vld_q[e_idx] <= 1'b1;
				hot_vld_q[e_idx] <= 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (in_op)
							OP_ROUTE: begin
								st_q <= ST_ROUTE;
								if (in_nb) begin
									cnt_vld_q <= '0;
									tc_q      <= '0;
								end
							end
							OP_READ: begin
								st_q <= ST_READ;
							end
							OP_TOPK: begin
								st_q    <= ST_SCAN;
								taken_q <= '0;
								i_q     <= '0;
								x_q     <= '0;
								have_q  <= 1'b0;
								k_q     <= KW'(k_clamp);
							end
							default: begin
								// unused opcode: drop the beat
							end
						endcase
					end
				end
				ST_ROUTE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
						if (tc_adv) begin
							tc_q <= tc_q + CNT_W'(1);
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					x_q <= x_q + EW'(1);
					if (x_q == EW'(NUM_EXPERTS - 1)) begin
						st_q <= ST_SDONE;
					end
				end
				ST_SDONE: begin
					st_q <= ST_CNTRD;
				end
				ST_CNTRD: begin
					taken_q[best_q] <= 1'b1;
					st_q            <= ST_TEMIT;
				end
				ST_TEMIT: begin
					if (out_free) begin
						if (topk_last) begin
							st_q <= ST_IDLE;
						end else begin
							st_q   <= ST_SCAN;
							i_q    <= i_q + KW'(1);
							x_q    <= '0;
							have_q <= 1'b0;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= x_q;
		if (acc) begin
			e_q    <= in_e;
			slot_q <= in_slot;
		end
		if (take) begin
			best_q   <= idx_s1;
			best_h_q <= hot_scan;
		end
		if (emit) begin
			out_q      <= res;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	assign m_tlast  = out_last_q;

	moetg_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_EXPERTS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(e_idx),
		.wdata(cnt_wd),
		.raddr(cnt_ra),
		.rdata(cnt_rd)
	);

	moetg_ram #(
		.WIDTH(HOT_W),
		.DEPTH(NUM_EXPERTS)
	) u_hot_ram (
		.clk  (clk),
		.we   (hot_we),
		.waddr(e_idx),
		.wdata(hot_wd),
		.raddr(hot_ra),
		.rdata(hot_rd)
	);

	moetg_ram #(
		.WIDTH(TOK_W),
		.DEPTH(TL_DEPTH)
	) u_tl_ram (
		.clk  (clk),
		.we   (tl_we),
		.waddr(tl_wa),
		.wdata(tc_q[TOK_W-1:0]),
		.raddr(tl_ra),
		.rdata(tl_rd)
	);

	// Each sweep starts with exactly one taken expert per beat already reported
	a_taken_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> ($countones(taken_q) == int'(i_q)))
		else $error("taken mask out of step with reported experts");

	// A stored count never passes the list capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (cnt_wd <= CAP_C))
		else $error("expert count written beyond capacity");

	// The batch token counter stops at the token space
	a_tc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tc_q <= TSP_C)
		else $error("token counter beyond token space");

	// A reported expert always exists
	a_hot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, out_q.hot_expert} < NE_X))
		else $error("reported expert id out of range");

endmodule
